/* hdl/cmw_pkg.sv */
package cmw_pkg;

   // sizes
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int CFG_W         = 11;
   localparam int COL_W         = 10;
   localparam int ROW_W         = 11;
   localparam int RND_W         = 8;
   localparam int OFS_W         = 12;
   localparam int SEED_W        = 5;
   localparam int STEP_W        = 7;
   localparam int QUEUE_DEPTH   = 2;

   // height / 25 as multiply and shift, exact for 11-bit heights
   localparam int STEP_RECIP = 1311;
   localparam int STEP_SHIFT = 15;

   // register reset values
   localparam logic [CFG_W-1:0]  WIDTH_RST  = CFG_W'(320);
   localparam logic [CFG_W-1:0]  HEIGHT_RST = CFG_W'(200);
   localparam logic [STEP_W-1:0] STEP_RST   = STEP_W'(200 / 25);

   // register indexes
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   // opcodes
   localparam logic [1:0] OP_INIT   = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_PEEK   = 2'd3;

   typedef enum logic [1:0] {
      CMD_INIT,
      CMD_TICK,
      CMD_LOOKUP,
      CMD_PEEK
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_SWEEP,
      BK_READ
   } back_state_type;

   typedef struct packed {
      logic [CFG_W-1:0]  width;
      logic [CFG_W-1:0]  height;
      logic [STEP_W-1:0] step;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
      logic [RND_W-1:0]  rnd;
      logic              col_ok;
      logic              init_ok;
   } cmd_type;

   typedef struct packed {
      logic                    changed;
      logic signed [OFS_W-1:0] value;
   } tick_res_type;

   typedef struct packed {
      logic             use_end;
      logic [ROW_W-1:0] src_row;
   } lookup_res_type;

   // byte mod 3: base-4 digits summed, since 4 is 1 mod 3
   function automatic logic [1:0] mod3(input logic [RND_W-1:0] b);
      logic [3:0] d;
      logic [1:0] r;
      d = 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]);
      unique case (d)
         4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
         4'd1, 4'd4, 4'd7, 4'd10:       r = 2'd1;
         4'd2, 4'd5, 4'd8, 4'd11:       r = 2'd2;
         default:                       r = 2'd0;
      endcase
      return r;
   endfunction

   // seed offset of one column
   function automatic logic signed [SEED_W-1:0] init_value(
      input logic                     first_col,
      input logic signed [SEED_W-1:0] prev,
      input logic [RND_W-1:0]         rnd);
      logic signed [SEED_W:0] s;
      if (first_col) begin
         s = -$signed({2'b00, rnd[3:0]});
      end else begin
         s = (SEED_W+1)'(prev) + $signed({4'b0000, mod3(rnd)}) - 6'sd1;
      end
      if (s > 6'sd0) begin
         s = 6'sd0;
      end else if (s < -6'sd15) begin
         s = -6'sd15;
      end
      return SEED_W'(s);
   endfunction

   // one tic of one column
   function automatic tick_res_type tick_update(
      input logic signed [OFS_W-1:0] y,
      input logic [CFG_W-1:0]        h,
      input logic [STEP_W-1:0]       step);
      tick_res_type           r;
      logic signed [OFS_W+1:0] yw;
      logic signed [OFS_W+1:0] hw;
      logic signed [OFS_W+1:0] dy;
      logic signed [OFS_W+1:0] sum;
      yw = (OFS_W+2)'(y);
      hw = $signed({3'b000, h});
      r.changed = 1'b0;
      r.value   = y;
      if (yw < 14'sd0) begin
         r.changed = 1'b1;
         r.value   = OFS_W'(yw + 14'sd1);
      end else if (yw < hw) begin
         dy  = (yw < 14'sd16) ? yw + 14'sd1 : $signed({7'b0000000, step});
         sum = yw + dy;
         r.changed = 1'b1;
         r.value   = (sum >= hw) ? OFS_W'(hw) : OFS_W'(sum);
      end
      return r;
   endfunction

   // which image and row a screen pixel shows
   function automatic lookup_res_type lookup(
      input logic signed [OFS_W-1:0] y,
      input logic [ROW_W-1:0]        row);
      lookup_res_type r;
      if (y < 12'sd0) begin
         r.use_end = 1'b0;
         r.src_row = row;
      end else if ($signed({2'b00, row}) < (OFS_W+1)'(y)) begin
         r.use_end = 1'b1;
         r.src_row = row;
      end else begin
         r.use_end = 1'b0;
         r.src_row = row - y[ROW_W-1:0];
      end
      return r;
   endfunction

endpackage

/* hdl/cmw_if.sv */
interface cmw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [9:0]  column;
   logic [10:0] row;
   logic [7:0]  random_byte;

   modport source (output valid, opcode, column, row, random_byte, input ready);
   modport sink   (input valid, opcode, column, row, random_byte, output ready);
endinterface

interface cmw_rsp_if;
   logic               valid;
   logic               ready;
   logic               melt_done;
   logic               use_end_image;
   logic [10:0]        source_row;
   logic signed [11:0] column_offset_out;

   modport source (output valid, melt_done, use_end_image, source_row, column_offset_out,
                   input ready);
   modport sink   (input valid, melt_done, use_end_image, source_row, column_offset_out,
                   output ready);
endinterface

/* hdl/cmw_front.sv */
module cmw_front #(
   parameter int MAX_WIDTH = cmw_pkg::MAX_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmw_pkg::cfg_type  cfg,
   input  logic              clearing,
   cmw_req_if.sink           req,
   input  logic              pop,
   output cmw_pkg::cmd_type  head,
   output logic              head_valid
);
   import cmw_pkg::*;

   cmd_type    q_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   cmd_type    cmd;

   // classify the incoming word
   always_comb begin
      cmd.column  = req.column;
      cmd.row     = req.row;
      cmd.rnd     = req.random_byte;
      cmd.col_ok  = 32'(req.column) < MAX_WIDTH;
      cmd.init_ok = cmd.col_ok && ({1'b0, req.column} < cfg.width);
      unique case (req.opcode)
         OP_INIT:   cmd.kind = CMD_INIT;
         OP_TICK:   cmd.kind = CMD_TICK;
         OP_LOOKUP: cmd.kind = CMD_LOOKUP;
         OP_PEEK:   cmd.kind = CMD_PEEK;
         default:   cmd.kind = CMD_PEEK;
      endcase
   end

   assign req.ready  = (count_ff != 2'(QUEUE_DEPTH)) && !clearing;
   assign push       = req.valid && req.ready;
   assign head       = q_ff[rd_ptr_ff];
   assign head_valid = count_ff != 2'd0;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = 2'(count_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

/* hdl/cmw_back.sv */
module cmw_back #(
   parameter int MAX_WIDTH = cmw_pkg::MAX_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmw_pkg::cfg_type  cfg,
   input  cmw_pkg::cmd_type  head,
   input  logic              head_valid,
   output logic              pop,
   output logic              clearing,
   cmw_rsp_if.source         rsp
);
   import cmw_pkg::*;

   localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CNT_W = $clog2(MAX_WIDTH + 1);

   back_state_type          state_ff, state_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        n_cols;
   logic                    pend_ff, pend_in;
   logic [AW-1:0]           wb_addr_ff, wb_addr_in;
   logic                    done_ff, done_in;
   cmd_type                 cmd_ff, cmd_in;
   logic signed [SEED_W-1:0] prev_ff, prev_in;

   logic signed [OFS_W-1:0] mem [MAX_WIDTH];
   logic signed [OFS_W-1:0] rd_data_ff;
   logic [AW-1:0]           mem_ra, mem_wa;
   logic                    mem_we;
   logic signed [OFS_W-1:0] mem_wd;

   logic                    out_valid_ff, out_valid_in;
   logic                    out_done_ff, out_done_in;
   logic                    out_end_ff, out_end_in;
   logic [ROW_W-1:0]        out_row_ff, out_row_in;
   logic signed [OFS_W-1:0] out_ofs_ff, out_ofs_in;

   tick_res_type             tres;
   lookup_res_type           lres;
   logic signed [SEED_W-1:0] init_v;
   logic signed [OFS_W-1:0]  cur_ofs;
   logic                     out_free;

   always_comb begin
      n_cols   = (32'(cfg.width) >= MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : CNT_W'(cfg.width);
      tres     = tick_update(rd_data_ff, cfg.height, cfg.step);
      cur_ofs  = cmd_ff.col_ok ? rd_data_ff : '0;
      lres     = lookup(cur_ofs, cmd_ff.row);
      init_v   = init_value(cmd_ff.column == '0, prev_ff, cmd_ff.rnd);
      out_free = !out_valid_ff || rsp.ready;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      wb_addr_in   = wb_addr_ff;
      done_in      = done_ff;
      cmd_in       = cmd_ff;
      prev_in      = prev_ff;
      pop          = 1'b0;
      mem_ra       = AW'(cmd_ff.column);
      mem_we       = 1'b0;
      mem_wa       = wb_addr_ff;
      mem_wd       = tres.value;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_done_in  = out_done_ff;
      out_end_in   = out_end_ff;
      out_row_in   = out_row_ff;
      out_ofs_in   = out_ofs_ff;

      unique case (state_ff)
         BK_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = AW'(idx_ff);
            mem_wd = '0;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CNT_W'(MAX_WIDTH - 1)) begin
               state_in = BK_IDLE;
               idx_in   = '0;
            end
         end
         BK_IDLE: begin
            mem_ra = AW'(head.column);
            if (head_valid && out_free) begin
               pop    = 1'b1;
               cmd_in = head;
               if (head.kind == CMD_TICK) begin
                  state_in = BK_SWEEP;
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  done_in  = 1'b1;
               end else begin
                  state_in = BK_READ;
               end
            end
         end
         BK_SWEEP: begin
            mem_ra = AW'(idx_ff);
            // write back the column read last cycle
            if (pend_ff) begin
               mem_we = 1'b1;
               if (tres.changed) begin
                  done_in = 1'b0;
               end
            end
            if (idx_ff < n_cols) begin
               pend_in    = 1'b1;
               wb_addr_in = AW'(idx_ff);
               idx_in     = idx_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  mem_ra   = AW'(cmd_ff.column);
                  state_in = BK_READ;
               end
            end
         end
         BK_READ: begin
            state_in     = BK_IDLE;
            out_valid_in = 1'b1;
            out_done_in  = 1'b0;
            out_end_in   = 1'b0;
            out_row_in   = '0;
            out_ofs_in   = cur_ofs;
            unique case (cmd_ff.kind)
               CMD_INIT: begin
                  if (cmd_ff.init_ok) begin
                     mem_we     = 1'b1;
                     mem_wa     = AW'(cmd_ff.column);
                     mem_wd     = OFS_W'(init_v);
                     prev_in    = init_v;
                     out_ofs_in = OFS_W'(init_v);
                  end
               end
               CMD_TICK: begin
                  out_done_in = done_ff;
               end
               CMD_LOOKUP: begin
                  out_end_in = lres.use_end;
                  out_row_in = lres.src_row;
               end
               CMD_PEEK: begin
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         done_ff      <= 1'b0;
         prev_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         done_ff      <= done_in;
         prev_ff      <= prev_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wb_addr_ff  <= wb_addr_in;
      cmd_ff      <= cmd_in;
      out_done_ff <= out_done_in;
      out_end_ff  <= out_end_in;
      out_row_ff  <= out_row_in;
      out_ofs_ff  <= out_ofs_in;
   end

   assign clearing              = state_ff == BK_CLEAR;
   assign rsp.valid             = out_valid_ff;
   assign rsp.melt_done         = out_done_ff;
   assign rsp.use_end_image     = out_end_ff;
   assign rsp.source_row        = out_row_ff;
   assign rsp.column_offset_out = out_ofs_ff;

endmodule

/* hdl/column_melt_wipe.sv */
// an init, lookup or peek word passes the queue, the command register and the offset
// memory read, then the result register on rsp; the back takes one word at a time, reading then using the offset
// a tick walks the min(screen_width, MAX_WIDTH) columns in use, one per cycle, and
// then shows on rsp; the back takes no new word while the result register is held
// reset: screen_width 320, screen_height 200, then a clearing pass zeroes every offset
// while req_chan.ready stays low; csr writes are taken throughout
module column_melt_wipe #(
   parameter int MAX_WIDTH = cmw_pkg::MAX_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wen,
   input  logic                       csr_index,
   input  logic [cmw_pkg::CFG_W-1:0]  csr_wdata,
   cmw_req_if.sink                    req_chan,
   cmw_rsp_if.source                  rsp_chan
);
   import cmw_pkg::*;

   // configuration registers
   logic [CFG_W-1:0]    width_ff, width_in;
   logic [CFG_W-1:0]    height_ff, height_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [2*CFG_W-1:0]  step_prod;
   cfg_type             cfg;

   // front to back
   cmd_type             head;
   logic                head_valid;
   logic                pop;
   logic                back_clearing;

   // large-offset step is height / 25, worked out once when height is written
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      step_in   = step_ff;
      step_prod = (2*CFG_W)'(csr_wdata) * (2*CFG_W)'(STEP_RECIP);
      if (csr_wen) begin
         unique case (csr_index)
            CSR_WIDTH: begin
               width_in = csr_wdata;
            end
            CSR_HEIGHT: begin
               height_in = csr_wdata;
               step_in   = step_prod[STEP_SHIFT +: STEP_W];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         step_ff   <= STEP_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         step_ff   <= step_in;
      end
   end

   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;
   assign cfg.step   = step_ff;

   // front: takes words, sorts them by kind and queues them
   cmw_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .clearing   (back_clearing),
      .req        (req_chan),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   // back: offset memory, tick sweep and result register
   cmw_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .clearing   (back_clearing),
      .rsp        (rsp_chan)
   );

   // back only takes queued words
   assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   // back only starts a word when the result register is free by then
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("start while result register is blocked");

   // nothing moves while the offsets are being cleared
   assert property (@(posedge clock) disable iff (reset)
      back_clearing |-> (!pop && !rsp_chan.valid && !req_chan.ready))
      else $error("activity during clearing pass");

endmodule
